/* sv/assert_macros.svh */
// Assertion macros used by the top level of the packet handler.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FQPH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fqph: same-cycle check failed");
// next-cycle implication
`define FQPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fqph: next-cycle check failed");
`else
`define FQPH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FQPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/fqph_pkg.sv */
// Package of the framed query packet handler: constants, codes and types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fqph_pkg;

   // sizes
   localparam int PACKET_DEPTH_DEFAULT = 10;
   localparam int COUNT_W              = 4;
   localparam int REPLY_MAX            = 7;
   localparam int LEN_W                = 3;
   localparam int QUEUE_DEPTH          = 2;
   localparam int CSR_INDEX_W          = 1;
   localparam int CSR_DATA_W           = 8;

   // protocol characters
   localparam logic [7:0] CH_AT     = 8'h40;  // '@'
   localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
   localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
   localparam logic [7:0] CH_AMP    = 8'h26;  // '&'
   localparam logic [7:0] CH_T      = 8'h74;  // 't'
   localparam logic [7:0] CH_H      = 8'h68;  // 'h'

   // data packet kinds carried in byte two
   localparam logic [7:0] KIND_TEMP = 8'd0;
   localparam logic [7:0] KIND_TIME = 8'd1;

   // afternoon offset for twelve hour clock
   localparam logic [7:0] HOUR_PM_OFFSET = 8'd12;

   // packet sizes that are acted upon
   localparam logic [COUNT_W-1:0] SIZE_QUERY = 4'd4;
   localparam logic [COUNT_W-1:0] SIZE_DATA  = 4'd7;

   // operations
   localparam logic OP_RX_BYTE = 1'b0;
   localparam logic OP_QUERY   = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MASTER_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OWN_ADDRESS = 1'd1;

   // register reset values
   localparam logic       MASTER_MODE_RESET = 1'b1;
   localparam logic [7:0] OWN_ADDRESS_RESET = 8'd50;

   // one reply run handed from front to back
   typedef struct packed {
      logic [REPLY_MAX-1:0][7:0] bytes;
      logic [LEN_W-1:0]          len;
      logic                      addr_flag;
      logic                      filter_on;
   } fqph_job_type;

   // queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } fqph_queue_status_type;

endpackage

`default_nettype wire

/* sv/fqph_req_if.sv */
// Request channel: one received byte or local query plus sensor and clock values.
// Depends on nothing.
`default_nettype none

interface fqph_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] rx_byte;
   logic [7:0] query_target;
   logic [7:0] query_code;
   logic [7:0] temp_whole;
   logic [3:0] temp_tenths;
   logic [4:0] clock_hour;
   logic       clock_twelve_hour;
   logic       clock_pm;
   logic [5:0] clock_minute;
   logic [5:0] clock_second;

   modport source (
      output valid, operation, rx_byte, query_target, query_code, temp_whole,
             temp_tenths, clock_hour, clock_twelve_hour, clock_pm, clock_minute,
             clock_second,
      input  ready
   );

   modport sink (
      input  valid, operation, rx_byte, query_target, query_code, temp_whole,
             temp_tenths, clock_hour, clock_twelve_hour, clock_pm, clock_minute,
             clock_second,
      output ready
   );
endinterface

`default_nettype wire

/* sv/fqph_rsp_if.sv */
// Response channel: one byte to transmit with its ninth bit and status flags.
// Depends on nothing.
`default_nettype none

interface fqph_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_address_flag;
   logic       filter_on;
   logic       last;

   modport source (
      output valid, tx_byte, tx_address_flag, filter_on, last,
      input  ready
   );

   modport sink (
      input  valid, tx_byte, tx_address_flag, filter_on, last,
      output ready
   );
endinterface

`default_nettype wire

/* sv/framed_query_packet_handler_unit.sv */
// Top level of the framed query packet handler for a 9-bit serial link.
// Depends on fqph_pkg, fqph_req_if, fqph_rsp_if, fqph_front, fqph_queue,
// fqph_back and assert_macros.svh.
//
//   channel  dir  handshake        payload
//   req_     in   valid / ready    operation, rx_byte, query fields, sensor, clock
//   rsp_     out  valid / ready    tx_byte, tx_address_flag, filter_on, last
//   csr_     in   csr_wr_en        csr_index, csr_wr_data
//
// A request word is classified in the cycle it is accepted. A reply of n words (1 to 7)
// leaves the output register one word per cycle while rsp_ ready is high. The two-entry
// job queue lets requests keep arriving while replies drain; ready drops only when the
// queue is full. Reset is synchronous.
`default_nettype none

`include "assert_macros.svh"

module framed_query_packet_handler_unit #(
   parameter int PACKET_DEPTH = fqph_pkg::PACKET_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [fqph_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fqph_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   fqph_req_if.sink                          req_chan,
   fqph_rsp_if.source                        rsp_chan
);

   fqph_pkg::fqph_job_type            new_job;
   fqph_pkg::fqph_job_type            head_job;
   fqph_pkg::fqph_queue_status_type   queue_status;
   logic                              job_push;
   logic                              job_pop;

   fqph_front #(
      .PACKET_DEPTH (PACKET_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .job_push     (job_push),
      .job          (new_job)
   );

   fqph_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (new_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   fqph_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .queue_status (queue_status),
      .job_pop      (job_pop),
      .rsp_chan     (rsp_chan)
   );

   // front never hands over a job the queue cannot take
   `FQPH_ASSERT_IMPLY(a_push_has_room, clock, reset, job_push, !queue_status.full)
   // every queued job carries one to seven words
   `FQPH_ASSERT_IMPLY(a_job_len_legal, clock, reset, !queue_status.empty, (head_job.len != '0) && (head_job.len <= fqph_pkg::LEN_W'(fqph_pkg::REPLY_MAX)))
   // reset leaves the queue empty
   `FQPH_ASSERT_NEXT(a_reset_empties_queue, clock, 1'b0, reset, queue_status.empty)
   // retiring a job puts its final word on the output
   `FQPH_ASSERT_NEXT(a_pop_shows_last, clock, reset, job_pop, rsp_chan.valid && rsp_chan.last)

endmodule

`default_nettype wire

/* sv/fqph_queue.sv */
// Short job queue between the front and back of the packet handler.
// Depends on fqph_pkg.
`default_nettype none

module fqph_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  fqph_pkg::fqph_job_type            push_job,
   input  logic                              pop,
   output fqph_pkg::fqph_job_type            head_job,
   output fqph_pkg::fqph_queue_status_type   status
);

   localparam int PTR_W = (fqph_pkg::QUEUE_DEPTH > 1) ? $clog2(fqph_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(fqph_pkg::QUEUE_DEPTH + 1);

   fqph_pkg::fqph_job_type entries_ff [fqph_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   // accept pushes only with room, pops only with data
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(fqph_pkg::QUEUE_DEPTH));
   assign head_job     = entries_ff[rd_ptr_ff];

   // advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(fqph_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(fqph_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold job payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* sv/fqph_front.sv */
// Front of the packet handler: takes request words, frames packets, holds the
// registers and protocol state, and turns each reply into a job. Depends on fqph_pkg.
`default_nettype none

module fqph_front #(
   parameter int PACKET_DEPTH = fqph_pkg::PACKET_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [fqph_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fqph_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   fqph_req_if.sink                              req_chan,
   input  fqph_pkg::fqph_queue_status_type       queue_status,
   output logic                                  job_push,
   output fqph_pkg::fqph_job_type                job
);

   localparam int COUNT_W   = fqph_pkg::COUNT_W;
   localparam int READ_TAPS = 6;

   logic                master_mode_ff, master_mode_in;
   logic [7:0]          own_address_ff, own_address_in;
   logic                collecting_ff,  collecting_in;
   logic [COUNT_W-1:0]  count_ff,       count_in;
   logic                selected_ff,    selected_in;
   logic [7:0]          store_ff [PACKET_DEPTH];
   logic [7:0]          store_in [PACKET_DEPTH];
   logic                store_we [PACKET_DEPTH];

   logic                accept;
   logic [7:0]          rx;
   logic [7:0]          tap [READ_TAPS];
   logic [COUNT_W-1:0]  count_next;
   logic                pkt_done;
   logic [7:0]          hour;

   assign req_chan.ready = !queue_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.rx_byte;
   assign count_next     = count_ff + 1'b1;
   assign pkt_done       = (rx == fqph_pkg::CH_HASH)
                        || ({1'b0, count_next} >= (COUNT_W + 1)'(PACKET_DEPTH))
                        || (count_next == '0);
   assign hour = {3'b000, req_chan.clock_hour}
               + ((req_chan.clock_twelve_hour && req_chan.clock_pm)
                  ? fqph_pkg::HOUR_PM_OFFSET : 8'd0);

   // read fixed store positions, forwarding the byte written this cycle
   for (genvar i = 0; i < READ_TAPS; i++) begin : g_tap
      if (i < PACKET_DEPTH) begin : g_in
         assign tap[i] = (collecting_ff && count_ff == COUNT_W'(i)) ? rx : store_ff[i];
      end else begin : g_out
         assign tap[i] = '0;
      end
   end

   // decode register writes
   always_comb begin
      master_mode_in = master_mode_ff;
      own_address_in = own_address_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fqph_pkg::REG_MASTER_MODE: master_mode_in = csr_wr_data[0];
            fqph_pkg::REG_OWN_ADDRESS: own_address_in = csr_wr_data[7:0];
         endcase
      end
   end

   // classify the word, update framing state, build the reply job
   always_comb begin
      collecting_in = collecting_ff;
      count_in      = count_ff;
      selected_in   = selected_ff;
      job_push      = 1'b0;
      job           = '0;
      for (int i = 0; i < PACKET_DEPTH; i++) begin
         store_we[i] = 1'b0;
         store_in[i] = rx;
      end

      if (accept) begin
         if (req_chan.operation == fqph_pkg::OP_QUERY) begin
            // load a new query and address the target
            if (master_mode_ff) begin
               store_we[0] = 1'b1;  store_in[0] = fqph_pkg::CH_AT;
               store_we[1] = 1'b1;  store_in[1] = req_chan.query_target;
               store_we[2] = 1'b1;  store_in[2] = req_chan.query_code;
               store_we[3] = 1'b1;  store_in[3] = fqph_pkg::CH_HASH;
               job.bytes[0]  = req_chan.query_target;
               job.len       = fqph_pkg::LEN_W'(1);
               job.addr_flag = 1'b1;
               job_push      = 1'b1;
            end
         end else if (master_mode_ff || selected_ff) begin
            if (!collecting_ff) begin
               if (rx == fqph_pkg::CH_AT) begin
                  collecting_in = 1'b1;
                  count_in      = COUNT_W'(1);
                  store_we[0]   = 1'b1;
               end else if (rx == fqph_pkg::CH_DOLLAR && master_mode_ff) begin
                  // re-send the held query
                  job.bytes[0] = tap[0];
                  job.bytes[1] = tap[1];
                  job.bytes[2] = tap[2];
                  job.bytes[3] = tap[3];
                  job.len      = fqph_pkg::LEN_W'(4);
                  job_push     = 1'b1;
               end
            end else begin
               for (int i = 0; i < PACKET_DEPTH; i++) begin
                  if (count_ff == COUNT_W'(i)) begin
                     store_we[i] = 1'b1;
                  end
               end
               count_in = count_next;
               if (pkt_done) begin
                  collecting_in = 1'b0;
                  count_in      = '0;
                  if (master_mode_ff) begin
                     if (count_next == fqph_pkg::SIZE_QUERY) begin
                        job.bytes[0]  = tap[1];
                        job.len       = fqph_pkg::LEN_W'(1);
                        job.addr_flag = 1'b1;
                        job_push      = 1'b1;
                     end else if (count_next == fqph_pkg::SIZE_DATA
                               && (tap[2] == fqph_pkg::KIND_TEMP
                                   || tap[2] == fqph_pkg::KIND_TIME)) begin
                        // forward data packet
                        job.bytes[0] = fqph_pkg::CH_AMP;
                        job.bytes[1] = 8'd0;
                        job.bytes[2] = tap[2];
                        job.bytes[3] = (tap[2] == fqph_pkg::KIND_TIME) ? tap[3] : 8'd0;
                        job.bytes[4] = tap[4];
                        job.bytes[5] = tap[5];
                        job.bytes[6] = fqph_pkg::CH_HASH;
                        job.len      = fqph_pkg::LEN_W'(7);
                        job_push     = 1'b1;
                     end
                  end else if (count_next == fqph_pkg::SIZE_QUERY) begin
                     if (tap[2] == fqph_pkg::CH_T) begin
                        // answer temperature and deselect
                        job.bytes[0] = fqph_pkg::CH_AT;
                        job.bytes[1] = 8'd0;
                        job.bytes[2] = fqph_pkg::KIND_TEMP;
                        job.bytes[3] = 8'd0;
                        job.bytes[4] = req_chan.temp_whole;
                        job.bytes[5] = {4'h0, req_chan.temp_tenths};
                        job.bytes[6] = fqph_pkg::CH_HASH;
                        job.len      = fqph_pkg::LEN_W'(7);
                        job_push     = 1'b1;
                        selected_in  = 1'b0;
                     end else if (tap[2] == fqph_pkg::CH_H) begin
                        // answer time and deselect
                        job.bytes[0] = fqph_pkg::CH_AT;
                        job.bytes[1] = 8'd0;
                        job.bytes[2] = fqph_pkg::KIND_TIME;
                        job.bytes[3] = hour;
                        job.bytes[4] = {2'b00, req_chan.clock_minute};
                        job.bytes[5] = {2'b00, req_chan.clock_second};
                        job.bytes[6] = fqph_pkg::CH_HASH;
                        job.len      = fqph_pkg::LEN_W'(7);
                        job_push     = 1'b1;
                        selected_in  = 1'b0;
                     end
                  end
               end
            end
         end else if (rx == own_address_ff) begin
            // select this station and acknowledge
            selected_in  = 1'b1;
            job.bytes[0] = fqph_pkg::CH_DOLLAR;
            job.len      = fqph_pkg::LEN_W'(1);
            job_push     = 1'b1;
         end
      end

      job.filter_on = !master_mode_ff && !selected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_mode_ff <= fqph_pkg::MASTER_MODE_RESET;
         own_address_ff <= fqph_pkg::OWN_ADDRESS_RESET;
         collecting_ff  <= 1'b0;
         count_ff       <= '0;
         selected_ff    <= 1'b0;
      end else begin
         master_mode_ff <= master_mode_in;
         own_address_ff <= own_address_in;
         collecting_ff  <= collecting_in;
         count_ff       <= count_in;
         selected_ff    <= selected_in;
      end
   end

   // hold packet bytes
   always_ff @(posedge clock) begin
      for (int i = 0; i < PACKET_DEPTH; i++) begin
         if (store_we[i]) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

endmodule

`default_nettype wire

/* sv/fqph_back.sv */
// Back of the packet handler: plays each queued job out as response words, one
// per cycle while rsp_chan.ready is high, through an output register. Depends on fqph_pkg.
`default_nettype none

module fqph_back (
   input  logic                              clock,
   input  logic                              reset,
   input  fqph_pkg::fqph_job_type            head_job,
   input  fqph_pkg::fqph_queue_status_type   queue_status,
   output logic                              job_pop,
   fqph_rsp_if.source                        rsp_chan
);

   localparam int LEN_W = fqph_pkg::LEN_W;

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       tx_byte_ff;
   logic             addr_flag_ff;
   logic             filter_ff;
   logic             last_ff;

   logic             advance;
   logic             load;
   logic             is_last;

   // refill the output register when empty or taken
   assign advance = !valid_ff || rsp_chan.ready;
   assign load    = advance && !queue_status.empty;
   assign is_last = (idx_ff == head_job.len - 1'b1);
   assign job_pop = load && is_last;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // capture the next word of the current job
   always_ff @(posedge clock) begin
      if (load) begin
         tx_byte_ff   <= head_job.bytes[idx_ff];
         addr_flag_ff <= head_job.addr_flag;
         filter_ff    <= head_job.filter_on;
         last_ff      <= is_last;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.tx_byte         = tx_byte_ff;
   assign rsp_chan.tx_address_flag = addr_flag_ff;
   assign rsp_chan.filter_on       = filter_ff;
   assign rsp_chan.last            = last_ff;

endmodule

`default_nettype wire
